### sv/hcbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared constants and types for the code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int MAX_CODE_BITS   = 16;
  localparam int SYMBOL_COUNT    = 256;
  localparam int FIELD_CODE_BITS = 16;
  localparam int LEN_LIMIT       = (MAX_CODE_BITS > FIELD_CODE_BITS) ?
                                   FIELD_CODE_BITS : MAX_CODE_BITS;
  localparam int SYM_W           = 8;
  localparam int SYM_AW          = $clog2(SYMBOL_COUNT);
  localparam int LEN_W           = 5;
  localparam int ENTRY_W         = FIELD_CODE_BITS + LEN_W;
  localparam int PEND_W          = 7;
  localparam int PCNT_W          = 3;
  localparam int ACC_W           = PEND_W + FIELD_CODE_BITS;
  localparam int CNT_W           = 5;
  localparam int OFIFO_DEPTH     = 4;
  localparam int OFIFO_AW        = 2;
  localparam int OFIFO_CW        = 3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } obyte_t;

  typedef struct packed {
    logic [1:0] cnt;
    obyte_t     e0;
    obyte_t     e1;
  } push_t;

  typedef struct packed {
    logic valid;
    logic flush;
  } s1_req_t;

  typedef struct packed {
    logic busy;
    logic s1_valid;
  } pk_stat_t;

endpackage

### sv/hcbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/hcbp_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pack
// Second stage: appends the looked-up code to the pending bits and splits
// off completed bytes, or pads out the partial byte on a flush.
// ----------------------------------------------------------------------------
module hcbp_pack (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hcbp_pkg::s1_req_t         req_i,
  input  logic [hcbp_pkg::ENTRY_W-1:0] entry_i,
  input  logic                      room_i,
  output hcbp_pkg::push_t           push_o,
  output hcbp_pkg::pk_stat_t        stat_o
);

  import hcbp_pkg::*;

  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_flush_q, s1_flush_d;
  logic [PEND_W-1:0]          pend_bits_q, pend_bits_d;
  logic [PCNT_W-1:0]          pend_cnt_q, pend_cnt_d;
  logic                       fire;
  logic [LEN_W-1:0]           len_raw, len_c;
  logic [FIELD_CODE_BITS-1:0] code;
  logic [ACC_W-1:0]           acc;
  logic [CNT_W-1:0]           cnt, sh0, sh1;
  logic [7:0]                 b0, b1, fbyte;
  logic [PCNT_W-1:0]          new_cnt;
  logic [PEND_W-1:0]          new_bits;

  assign fire = s1_valid_q && room_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_flush_d = s1_flush_q;
    if (req_i.valid) begin
      s1_valid_d = 1'b1;
      s1_flush_d = req_i.flush;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    len_raw  = entry_i[ENTRY_W-1 -: LEN_W];
    code     = entry_i[FIELD_CODE_BITS-1:0];
    len_c    = (len_raw > LEN_W'(FIELD_CODE_BITS)) ? LEN_W'(FIELD_CODE_BITS) : len_raw;
    acc      = (ACC_W'(pend_bits_q) << len_c) | ACC_W'(code);
    cnt      = CNT_W'(pend_cnt_q) + CNT_W'(len_c);
    sh0      = cnt - CNT_W'(8);
    sh1      = cnt - CNT_W'(16);
    b0       = 8'(acc >> sh0);
    b1       = 8'(acc >> sh1);
    new_cnt  = cnt[PCNT_W-1:0];
    new_bits = PEND_W'(acc) & PEND_W'((8'd1 << new_cnt) - 8'd1);
    fbyte    = 8'({1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q}));
  end

  always_comb begin
    push_o      = '0;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    if (fire) begin
      if (s1_flush_q) begin
        if (pend_cnt_q != '0) begin
          push_o.cnt     = 2'd1;
          push_o.e0.data = fbyte;
          push_o.e0.last = 1'b1;
        end
        pend_bits_d = '0;
        pend_cnt_d  = '0;
      end else begin
        case (cnt[4:3])
          2'd1: begin
            push_o.cnt     = 2'd1;
            push_o.e0.data = b0;
            push_o.e0.last = 1'b1;
          end
          2'd2: begin
            push_o.cnt     = 2'd2;
            push_o.e0.data = b0;
            push_o.e0.last = 1'b0;
            push_o.e1.data = b1;
            push_o.e1.last = 1'b1;
          end
          default: ;
        endcase
        pend_bits_d = new_bits;
        pend_cnt_d  = new_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_flush_q <= s1_flush_d;
  end

  assign stat_o.busy     = s1_valid_q && !room_i;
  assign stat_o.s1_valid = s1_valid_q;

endmodule

### sv/hcbp_ofifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_ofifo
// Output byte queue: takes up to two bytes a cycle, hands out one.
// ----------------------------------------------------------------------------
module hcbp_ofifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hcbp_pkg::push_t               push_i,
  input  logic                          pop_i,
  output hcbp_pkg::obyte_t              head_o,
  output logic                          valid_o,
  output logic [hcbp_pkg::OFIFO_CW-1:0] free_o
);

  import hcbp_pkg::*;

  obyte_t              mem_q [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OFIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OFIFO_CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + OFIFO_AW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + OFIFO_AW'(pop_i);
    cnt_d    = cnt_q + OFIFO_CW'(push_i.cnt) - OFIFO_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.e0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + OFIFO_AW'(1)] <= push_i.e1;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign free_o  = OFIFO_CW'(OFIFO_DEPTH) - cnt_q;

endmodule

### sv/huffman_code_bit_packer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Code table lookup and bit packer for a variable-length code encoder.
// ----------------------------------------------------------------------------
// A new transaction can be accepted every cycle unless the input is stalled.
// Loads write the code table RAM in the cycle they are accepted; encodes of a
// nonzero symbol read it, and the packing stage appends the registered code
// and emits zero, one or two bytes into a four-entry output queue. The output
// port delivers one byte per cycle unless stalled, which sets the sustained
// rate when codes produce bytes faster than that; the input is stalled while
// the packing stage waits for two free queue slots.
module huffman_code_bit_packer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          op_i,
  input  logic [hcbp_pkg::SYM_W-1:0]          symbol_i,
  input  logic [hcbp_pkg::FIELD_CODE_BITS-1:0] code_value_i,
  input  logic [hcbp_pkg::LEN_W-1:0]          code_length_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          out_byte_o,
  output logic                                last_o
);

  import hcbp_pkg::*;

  op_e                        op;
  logic                       in_acc;
  logic                       sym_ok;
  logic                       we, re;
  logic [LEN_W-1:0]           len_sat;
  logic [FIELD_CODE_BITS-1:0] code_mask;
  logic [ENTRY_W-1:0]         wdata, rdata;
  s1_req_t                    req;
  push_t                      push;
  pk_stat_t                   stat;
  obyte_t                     head;
  logic [OFIFO_CW-1:0]        free;
  logic                       room;

  assign op     = op_e'(op_i);
  assign in_acc = in_valid_i && !in_stall_o;
  assign sym_ok = ({1'b0, symbol_i} < (SYM_W + 1)'(SYMBOL_COUNT));

  always_comb begin
    len_sat   = (code_length_i > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length_i;
    code_mask = FIELD_CODE_BITS'(((FIELD_CODE_BITS + 1)'(1) << len_sat)
                                 - (FIELD_CODE_BITS + 1)'(1));
    wdata     = {len_sat, code_value_i & code_mask};
  end

  always_comb begin
    we  = 1'b0;
    re  = 1'b0;
    req = '0;
    unique case (op)
      OP_LOAD: begin
        we = in_acc && sym_ok;
      end
      OP_ENCODE: begin
        re        = in_acc && sym_ok && (symbol_i != '0);
        req.valid = re;
      end
      OP_FLUSH: begin
        req.valid = in_acc;
        req.flush = 1'b1;
      end
      default: ;
    endcase
  end

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (symbol_i[SYM_AW-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (symbol_i[SYM_AW-1:0]),
    .rdata_o (rdata)
  );

  hcbp_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .entry_i (rdata),
    .room_i  (room),
    .push_o  (push),
    .stat_o  (stat)
  );

  hcbp_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o && !out_stall_i),
    .head_o  (head),
    .valid_o (out_valid_o),
    .free_o  (free)
  );

  assign room       = (free >= OFIFO_CW'(2));
  assign in_stall_o = stat.busy;
  assign out_byte_o = head.data;
  assign last_o     = head.last;

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OFIFO_CW'(push.cnt) <= free)
    else $error("byte push overruns output queue");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> stat.s1_valid)
    else $error("input stalled with empty packing stage");

  a_req_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid |=> stat.s1_valid)
    else $error("accepted transaction lost before packing stage");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |-> (!push.e0.last && push.e1.last))
    else $error("last flag misplaced on byte pair");

endmodule
